>>> src/cgbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgbs_pkg: shared types and constants of the cost grid bilinear sampler
// Op codes, register indexes, config and queue entry types.
// ----------------------------------------------------------------------------
package cgbs_pkg;

	localparam int unsigned DEFAULT_MAX_WIDTH  = 256;
	localparam int unsigned DEFAULT_MAX_HEIGHT = 256;

	// Depth of the queue between front and back (power of two)
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QLW         = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [15:0] OUTSIDE_COST   = 16'hFF00;
	localparam logic [15:0] RST_CELLS_PER_M = 16'd5120;
	localparam logic [8:0]  RST_MAP_DIM    = 9'd256;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_CELLS_PER_M = 3'd2,
		REG_MAP_WIDTH  = 3'd3,
		REG_MAP_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] org_x;
		logic signed [15:0] org_y;
		logic [15:0]        cells_per_metre;
		logic [8:0]         map_width;
		logic [8:0]         map_height;
	} cfg_t;

	// One classified item as it waits for the back end
	typedef struct packed {
		op_t         op;
		logic [15:0] cell_index;
		logic [7:0]  cell_cost;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [7:0]  fx;
		logic [7:0]  fy;
		logic        outside;
	} queue_entry_t;

	typedef struct packed {
		logic           head_valid;
		logic [QLW-1:0] level;
	} queue_status_t;

endpackage
`default_nettype wire

>>> src/cost_grid_bilinear_sampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cost_grid_bilinear_sampler_core: bilinear sampler over an 8-bit cost grid
// Stores cost cells and answers position queries with a blended Q8.8 cost.
// ----------------------------------------------------------------------------
// One item is taken per clock. A write (op = 0) stores cell_cost at
// cell_index and gives no result; a query (op = 1) gives exactly one result,
// strobed by done as the query leaves the pipe. Results come out in
// the order the queries went in and cannot be held off, so take each one in
// the cycle done is high. Timing is set by the seven register stages: origin
// subtract, scale multiply, queue, neighbor index, cell store read, row
// blend, column blend into the output register. The back end drains one
// queue entry every cycle, so the queue never holds more than one entry and
// busy never rises. The cell store holds two copies of
// MAX_WIDTH*MAX_HEIGHT bytes, each written once and read twice per cycle,
// which is what lets all four neighbors be fetched together. The store is
// not cleared after reset: read only cells that were written. There is no
// clearing pass, so items are taken from the first cycle after reset.
// The user writes registers through the cfg_* port (always ready) only while
// no query is in flight; the block does not enforce this. A map_width or
// map_height above the compiled maximum is used as the maximum.
// ----------------------------------------------------------------------------
module cost_grid_bilinear_sampler_core #(
	parameter int unsigned MAX_WIDTH  = cgbs_pkg::DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cgbs_pkg::DEFAULT_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             op,
	input  wire logic [15:0]                      cell_index,
	input  wire logic [7:0]                       cell_cost,
	input  wire logic signed [15:0]               pos_x,
	input  wire logic signed [15:0]               pos_y,
	// result channel
	output logic                                  done,
	output logic [15:0]                           cost_value,
	output logic                                  outside_map,
	// register write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cgbs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]                      cfg_data
);
	import cgbs_pkg::*;

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned PIPE_LATENCY = 7;

	cfg_t          cfg_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic          push;
	queue_entry_t  push_entry;
	queue_status_t qstat;
	queue_entry_t  head;

	// Register file: every transfer lands at once, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.org_x           <= '0;
			cfg_q.org_y           <= '0;
			cfg_q.cells_per_metre <= RST_CELLS_PER_M;
			cfg_q.map_width       <= RST_MAP_DIM;
			cfg_q.map_height      <= RST_MAP_DIM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:    cfg_q.org_x           <= cfg_data;
				REG_ORIGIN_Y:    cfg_q.org_y           <= cfg_data;
				REG_CELLS_PER_M: cfg_q.cells_per_metre <= cfg_data;
				REG_MAP_WIDTH:   cfg_q.map_width       <= cfg_data[8:0];
				REG_MAP_HEIGHT:  cfg_q.map_height      <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Clamp the map size to what the store can hold
	always_comb begin
		if (32'(cfg_q.map_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_q.map_width);
		end
		if (32'(cfg_q.map_height) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_q.map_height);
		end
	end

	cgbs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.cell_index (cell_index),
		.cell_cost  (cell_cost),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.cfg        (cfg_q),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.qstat      (qstat),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry)
	);

	cgbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat),
		.head       (head)
	);

	cgbs_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (qstat.head_valid),
		.head        (head),
		.w_eff       (w_eff),
		.done        (done),
		.cost_value  (cost_value),
		.outside_map (outside_map)
	);

`ifndef SYNTHESIS
	// every result traces back to a query transfer a fixed time earlier
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (op == OP_QUERY), PIPE_LATENCY))
		else $error("result without matching query");
`endif

endmodule
`default_nettype wire

>>> src/cgbs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgbs_front: item intake and classification
// Subtracts the origin, scales to grid coordinates, splits cell and
// fraction and flags neighborhoods that leave the map.
// ----------------------------------------------------------------------------
module cgbs_front #(
	parameter int unsigned MAX_WIDTH  = cgbs_pkg::DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cgbs_pkg::DEFAULT_MAX_HEIGHT,
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   op,
	input  wire logic [15:0]            cell_index,
	input  wire logic [7:0]             cell_cost,
	input  wire logic signed [15:0]     pos_x,
	input  wire logic signed [15:0]     pos_y,
	input  wire cgbs_pkg::cfg_t         cfg,
	input  wire logic [WW-1:0]          w_eff,
	input  wire logic [HW-1:0]          h_eff,
	input  wire cgbs_pkg::queue_status_t qstat,
	output logic                        busy,
	output logic                        push,
	output cgbs_pkg::queue_entry_t      push_entry
);
	import cgbs_pkg::*;

	logic               accept;
	logic               valid_s1;
	op_t                op_s1;
	logic [15:0]        index_s1;
	logic [7:0]         cost_s1;
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;

	logic               valid_s2;
	op_t                op_s2;
	logic [15:0]        index_s2;
	logic [7:0]         cost_s2;
	logic signed [33:0] gx_s2;
	logic signed [33:0] gy_s2;

	logic signed [16:0] cpm_s;
	logic [16:0]        x1;
	logic [16:0]        y1;

	// Hold off intake once queue plus in-flight items could fill the queue
	assign busy   = (32'(qstat.level) + 32'(valid_s1) + 32'(valid_s2)) >= QUEUE_DEPTH;
	assign accept = start && !busy;
	assign cpm_s  = $signed({1'b0, cfg.cells_per_metre});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= op_t'(op);
		index_s1 <= cell_index;
		cost_s1  <= cell_cost;
		dx_s1    <= {pos_x[15], pos_x} - {cfg.org_x[15], cfg.org_x};
		dy_s1    <= {pos_y[15], pos_y} - {cfg.org_y[15], cfg.org_y};

		op_s2    <= op_s1;
		index_s2 <= index_s1;
		cost_s2  <= cost_s1;
		gx_s2    <= 34'(dx_s1) * 34'(cpm_s);
		gy_s2    <= 34'(dy_s1) * 34'(cpm_s);
	end

	// Q16.16 grid coordinate: integer cell in [31:16], blend weight in [15:8]
	assign x1 = {1'b0, gx_s2[31:16]} + 17'd1;
	assign y1 = {1'b0, gy_s2[31:16]} + 17'd1;

	always_comb begin
		push                  = valid_s2;
		push_entry.op         = op_s2;
		push_entry.cell_index = index_s2;
		push_entry.cell_cost  = cost_s2;
		push_entry.x0         = gx_s2[31:16];
		push_entry.y0         = gy_s2[31:16];
		push_entry.fx         = gx_s2[15:8];
		push_entry.fy         = gy_s2[15:8];
		push_entry.outside    = gx_s2[33] || gy_s2[33]
		                     || (x1 >= 17'(w_eff)) || (y1 >= 17'(h_eff));
	end

endmodule
`default_nettype wire

>>> src/cgbs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgbs_queue: short queue between front and back
// Classified items wait here; the back end takes the head each cycle.
// ----------------------------------------------------------------------------
module cgbs_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire cgbs_pkg::queue_entry_t push_entry,
	output cgbs_pkg::queue_status_t     qstat,
	output cgbs_pkg::queue_entry_t      head
);
	import cgbs_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	queue_entry_t   entries_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [QLW-1:0] level_q;
	logic           pop;

	// back end never stalls: the head leaves as soon as it is there
	assign pop              = level_q != '0;
	assign qstat.head_valid = pop;
	assign qstat.level      = level_q;
	assign head             = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (pop)  rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			case ({push, pop})
				2'b10:   level_q <= QLW'(level_q + 1'b1);
				2'b01:   level_q <= QLW'(level_q - 1'b1);
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_entry;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> 32'(level_q) < QUEUE_DEPTH)
		else $error("queue overflow");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> level_q != '0)
		else $error("pushed entry lost");
`endif

endmodule
`default_nettype wire

>>> src/cgbs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgbs_back: cell store and bilinear blend
// Writes cells, fetches the 2x2 neighborhood and blends row then column.
// ----------------------------------------------------------------------------
module cgbs_back #(
	parameter int unsigned MAX_WIDTH  = cgbs_pkg::DEFAULT_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = cgbs_pkg::DEFAULT_MAX_HEIGHT,
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire cgbs_pkg::queue_entry_t head,
	input  wire logic [WW-1:0]          w_eff,
	output logic                        done,
	output logic [15:0]                 cost_value,
	output logic                        outside_map
);
	import cgbs_pkg::*;

	localparam int unsigned CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW  = $clog2(CELL_COUNT);
	localparam int unsigned XW  = $clog2(MAX_WIDTH);
	localparam int unsigned YW  = $clog2(MAX_HEIGHT);
	localparam int unsigned PRW = YW + WW;

	// two copies, each one write and two reads per cycle
	logic [7:0] mem_a [CELL_COUNT];
	logic [7:0] mem_b [CELL_COUNT];

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [PRW-1:0] row_base;

	logic          valid_s3;
	logic          outside_s3;
	logic [7:0]    fx_s3;
	logic [7:0]    fy_s3;
	logic [AW-1:0] base_s3;

	logic [AW-1:0] a10;
	logic [AW-1:0] a01;
	logic [AW-1:0] a11;

	logic       valid_s4;
	logic       outside_s4;
	logic [7:0] fx_s4;
	logic [7:0] fy_s4;
	logic [7:0] c00_s4;
	logic [7:0] c10_s4;
	logic [7:0] c01_s4;
	logic [7:0] c11_s4;

	logic [8:0]  wfx;
	logic [16:0] row0;
	logic [16:0] row1;

	logic        valid_s5;
	logic        outside_s5;
	logic [7:0]  fy_s5;
	logic [15:0] r0_s5;
	logic [15:0] r1_s5;

	logic [8:0]  wfy;
	logic [24:0] blend;

	logic        done_q;
	logic [15:0] cost_q;
	logic        outside_q;

	assign wr_en   = head_valid && (head.op == OP_WRITE)
	              && (32'(head.cell_index) < CELL_COUNT);
	assign wr_addr = AW'(head.cell_index);

	always_ff @(posedge clk) begin
		if (wr_en) mem_a[wr_addr] <= head.cell_cost;
		c00_s4 <= mem_a[base_s3];
		c10_s4 <= mem_a[a10];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_b[wr_addr] <= head.cell_cost;
		c01_s4 <= mem_b[a01];
		c11_s4 <= mem_b[a11];
	end

	// row start of the top-left neighbor's linear index
	assign row_base = PRW'(head.y0[YW-1:0]) * PRW'(w_eff);

	assign a10 = AW'(base_s3 + 1'b1);
	assign a01 = AW'(base_s3 + AW'(w_eff));
	assign a11 = AW'(a01 + 1'b1);

	assign wfx  = 9'd256 - {1'b0, fx_s4};
	assign row0 = 17'(wfx) * 17'(c00_s4) + 17'(fx_s4) * 17'(c10_s4);
	assign row1 = 17'(wfx) * 17'(c01_s4) + 17'(fx_s4) * 17'(c11_s4);

	assign wfy   = 9'd256 - {1'b0, fy_s5};
	assign blend = 25'(wfy) * 25'(r0_s5) + 25'(fy_s5) * 25'(r1_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s3 <= head_valid && (head.op == OP_QUERY);
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		outside_s3 <= head.outside;
		fx_s3      <= head.fx;
		fy_s3      <= head.fy;
		base_s3    <= AW'(row_base[AW-1:0] + AW'(head.x0[XW-1:0]));

		outside_s4 <= outside_s3;
		fx_s4      <= fx_s3;
		fy_s4      <= fy_s3;

		outside_s5 <= outside_s4;
		fy_s5      <= fy_s4;
		r0_s5      <= row0[15:0];
		r1_s5      <= row1[15:0];

		outside_q  <= outside_s5;
		cost_q     <= outside_s5 ? OUTSIDE_COST : blend[23:8];
	end

	assign done        = done_q;
	assign cost_value  = cost_q;
	assign outside_map = outside_q;

`ifndef SYNTHESIS
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cost_q <= OUTSIDE_COST)
		else $error("blended cost above full scale");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cost_grid_bilinear_sampler_core
// Drives cell writes and position queries across several map settings, predicts
// every blended cost in the bench, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
	import cgbs_pkg::*;

	// Quiet time after the last result before a register write or the end.
	// Writes give no result, so this covers the seven-stage pipe with margin.
	localparam int QUIET_CYCLES  = 12;
	// Cycles with no transfer of any kind before the run is called hung
	localparam int IDLE_LIMIT    = 2000;
	// Mismatch lines printed before going silent (all are still counted)
	localparam int REPORT_CAP    = 50;
	localparam longint MAX_COLS  = DEFAULT_MAX_WIDTH;
	localparam longint MAX_ROWS  = DEFAULT_MAX_HEIGHT;
	localparam int CELL_TOTAL    = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT;

	// One input item as the driver presents it
	typedef struct packed {
		op_t                op;
		logic [15:0]        cell_index;
		logic [7:0]         cell_cost;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} grid_item_t;

	// One expected query answer
	typedef struct packed {
		logic [15:0] cost;
		logic        outside;
	} cost_sample_t;

	// Where a position lands on the grid under the current map setting
	typedef struct {
		bit          in_map;
		longint      col;
		longint      row;
		longint      wide;
		int unsigned fx;
		int unsigned fy;
	} grid_spot_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               start       = 1'b0;
	logic               busy;
	logic               op          = OP_WRITE;
	logic [15:0]        cell_index  = '0;
	logic [7:0]         cell_cost   = '0;
	logic signed [15:0] pos_x       = '0;
	logic signed [15:0] pos_y       = '0;
	logic               done;
	logic [15:0]        cost_value;
	logic               outside_map;
	logic               cfg_valid   = 1'b0;
	logic               cfg_ready;
	cfg_reg_t           cfg_index   = REG_ORIGIN_X;
	logic [15:0]        cfg_data    = '0;

	cost_grid_bilinear_sampler_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.cell_index  (cell_index),
		.cell_cost   (cell_cost),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.done        (done),
		.cost_value  (cost_value),
		.outside_map (outside_map),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Bench copy of the block's state: map setting and cost cells. The setting
	// follows every register transfer; the cells follow every accepted write.
	// ------------------------------------------------------------------------
	logic signed [15:0] map_org_x    = '0;
	logic signed [15:0] map_org_y    = '0;
	logic [15:0]        map_scale    = RST_CELLS_PER_M;
	logic [8:0]         map_cols     = RST_MAP_DIM;
	logic [8:0]         map_rows     = RST_MAP_DIM;
	logic [7:0]         cell_model [CELL_TOTAL];

	// Cells that the stimulus has already queued a write for. Queries only
	// touch neighborhoods whose four cells are all in here, since the store
	// holds garbage until written.
	bit                 cell_filled [CELL_TOTAL];

	grid_item_t   pending_items [$];
	cost_sample_t expected_costs [$];

	int unsigned  gap_pct       = 0;    // chance in 100 that the driver idles
	bit           item_xfer     = 1'b0; // item transfer at the last rising edge
	int unsigned  reg_xfers     = 0;
	int unsigned  items_taken   = 0;
	int unsigned  queries_taken = 0;
	int unsigned  outside_seen  = 0;
	int unsigned  map_settings  = 0;
	int unsigned  mismatches    = 0;
	int unsigned  quiet_cycles  = 0;

	task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("ERROR t=%0t %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Floor the scaled offset to a cell and keep 8 fraction bits per axis.
	// The offset times the scale is exact in 64 bits, so no wrap to mimic.
	function automatic grid_spot_t locate(logic signed [15:0] px, logic signed [15:0] py);
		grid_spot_t s;
		longint     gx;
		longint     gy;
		longint     tall;
		s.wide = (map_cols > MAX_COLS) ? MAX_COLS : longint'(map_cols);
		tall   = (map_rows > MAX_ROWS) ? MAX_ROWS : longint'(map_rows);
		gx = (longint'(px) - longint'(map_org_x)) * longint'(map_scale);
		gy = (longint'(py) - longint'(map_org_y)) * longint'(map_scale);
		s.in_map = 1'b0;
		s.col = 0;
		s.row = 0;
		s.fx = 0;
		s.fy = 0;
		if (gx >= 0 && gy >= 0) begin
			s.col = gx >>> 16;
			s.row = gy >>> 16;
			s.fx = int'((gx >>> 8) & 255);
			s.fy = int'((gy >>> 8) & 255);
			s.in_map = (s.col + 1 < s.wide) && (s.row + 1 < tall);
		end
		return s;
	endfunction

	// Expected answer of one query: weighted blend of the 2x2 neighborhood,
	// or the saturated cost with the flag when the neighborhood leaves the map
	function automatic cost_sample_t blend_cost(logic signed [15:0] px,
		logic signed [15:0] py);
		grid_spot_t   s;
		cost_sample_t r;
		longint       base;
		int unsigned  c00;
		int unsigned  c10;
		int unsigned  c01;
		int unsigned  c11;
		int unsigned  sum;
		s = locate(px, py);
		if (!s.in_map) begin
			r.cost = OUTSIDE_COST;
			r.outside = 1'b1;
			return r;
		end
		base = s.row * s.wide + s.col;
		c00 = 32'(cell_model[base]);
		c10 = 32'(cell_model[base + 1]);
		c01 = 32'(cell_model[base + s.wide]);
		c11 = 32'(cell_model[base + s.wide + 1]);
		sum = (256 - s.fx) * (256 - s.fy) * c00 + s.fx * (256 - s.fy) * c10
			+ (256 - s.fx) * s.fy * c01 + s.fx * s.fy * c11;
		r.cost = sum[23:8];
		r.outside = 1'b0;
		return r;
	endfunction

	// Pick a coordinate on one axis that mostly lands inside the map; one in
	// eight sits at the far edge of the usable span to hit the boundary.
	function automatic logic signed [15:0] aim_axis(logic signed [15:0] origin,
		logic [8:0] extent);
		longint n;
		longint span;
		longint v;
		n = (extent > MAX_COLS) ? MAX_COLS : longint'(extent);
		if (map_scale == 0)
			span = 65535;
		else
			span = ((n - 1) * 65536 - 1) / longint'(map_scale);
		if (span > 65535)
			span = 65535;
		if (span < 0)
			span = 0;
		if ($urandom_range(0, 7) == 0)
			v = longint'(origin) + span;
		else
			v = longint'(origin) + longint'($urandom_range(0, int'(span)));
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	task automatic push_write(int unsigned idx, int unsigned cost);
		grid_item_t it;
		it.op = OP_WRITE;
		it.cell_index = idx[15:0];
		it.cell_cost = cost[7:0];
		it.pos_x = 16'($urandom());
		it.pos_y = 16'($urandom());
		cell_filled[idx[15:0]] = 1'b1;
		pending_items.insert(pending_items.size(), it);
	endtask

	// Queue a query, first filling any neighbor cell not yet written
	task automatic push_query(logic signed [15:0] px, logic signed [15:0] py);
		grid_item_t  it;
		grid_spot_t  s;
		longint      base;
		longint      nb [4];
		s = locate(px, py);
		if (s.in_map) begin
			base = s.row * s.wide + s.col;
			nb = '{base, base + 1, base + s.wide, base + s.wide + 1};
			foreach (nb[k])
				if (!cell_filled[nb[k]])
					push_write(int'(nb[k]), $urandom_range(0, 255));
		end
		it.op = OP_QUERY;
		it.cell_index = 16'($urandom());
		it.cell_cost = 8'($urandom());
		it.pos_x = px;
		it.pos_y = py;
		pending_items.insert(pending_items.size(), it);
	endtask

	// Random traffic: mostly aimed queries, plus noise writes and wild queries
	task automatic fill_random(int n);
		int unsigned pick;
		while (pending_items.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				push_write($urandom_range(0, 65535), $urandom_range(0, 255));
			else if (pick < 80)
				push_query(aim_axis(map_org_x, map_cols), aim_axis(map_org_y, map_rows));
			else
				push_query(16'($urandom()), 16'($urandom()));
		end
	endtask

	// Hold valid through back-to-back register transfers; the caller drops it
	task automatic reg_write(cfg_reg_t r, logic [15:0] d);
		int unsigned target;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		target = reg_xfers + 1;
		wait (reg_xfers == target);
	endtask

	task automatic set_map(int ox, int oy, int scale, int cols, int rows);
		reg_write(REG_ORIGIN_X, ox[15:0]);
		reg_write(REG_ORIGIN_Y, oy[15:0]);
		reg_write(REG_CELLS_PER_M, scale[15:0]);
		reg_write(REG_MAP_WIDTH, cols[15:0]);
		reg_write(REG_MAP_HEIGHT, rows[15:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
		map_settings++;
	endtask

	// Wait until every queued item went in and every answer came back, then
	// let trailing writes leave the pipe
	task automatic settle();
		while (pending_items.size() != 0 || start || expected_costs.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents items on the falling edge. A presented item stays put
	// until it transfers; the next one (or an idle cycle) follows right after.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		grid_item_t it;
		if (arst_n && (!start || item_xfer)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				it = pending_items.pop_front();
				start <= 1'b1;
				op <= it.op;
				cell_index <= it.cell_index;
				cell_cost <= it.cell_cost;
				pos_x <= it.pos_x;
				pos_y <= it.pos_y;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: at each rising edge checks a strobed result against the oldest
	// expectation, folds an accepted item or register transfer into the bench
	// state, and runs the hang watchdog.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cost_sample_t want;
		if (arst_n) begin
			item_xfer <= start && !busy;

			if (done) begin
				if (expected_costs.size() == 0) begin
					report_mismatch("result with no query waiting", '0, cost_value);
				end else begin
					want = expected_costs.pop_front();
					if (cost_value !== want.cost)
						report_mismatch("cost_value", want.cost, cost_value);
					if (outside_map !== want.outside)
						report_mismatch("outside_map", 16'(want.outside), 16'(outside_map));
				end
			end

			if (start && !busy) begin
				items_taken++;
				if (op == OP_WRITE) begin
					cell_model[cell_index] = cell_cost;
				end else begin
					want = blend_cost(pos_x, pos_y);
					expected_costs.insert(expected_costs.size(), want);
					queries_taken++;
					if (want.outside)
						outside_seen++;
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_X: map_org_x = cfg_data;
					REG_ORIGIN_Y: map_org_y = cfg_data;
					REG_CELLS_PER_M: map_scale = cfg_data;
					REG_MAP_WIDTH: map_cols = cfg_data[8:0];
					REG_MAP_HEIGHT: map_rows = cfg_data[8:0];
					default: ;
				endcase
				reg_xfers++;
			end

			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus plan: directed corner items at the reset map, then fixed corner
	// map settings, then random settings. The driver idles often in the first
	// third, heavily in the second, and never in the last.
	// ------------------------------------------------------------------------
	int plan_ox    [6] = '{-1280, -32768, 32767, 0, 1000, -512};
	int plan_oy    [6] = '{768, -32768, 32767, -256, 0, 512};
	int plan_scale [6] = '{256, 65535, 1, 0, 5120, 2560};
	int plan_cols  [6] = '{16, 256, 2, 300, 0, 511};
	int plan_rows  [6] = '{12, 256, 2, 1, 511, 256};

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset map: origin 0, 20 cells per metre, 256 x 256 cells
		gap_pct = 14;
		push_write(0, 255);
		push_write(1, 0);
		push_write(256, 128);
		push_write(257, 1);
		push_write(65535, 255);
		push_query(16'sd0, 16'sd0);             // exact cell corner, no blend
		push_query(16'sd12, 16'sd12);           // large fractions on both axes
		push_query(16'sd13, 16'sd0);            // next column, small fraction
		push_query(16'sd3263, 16'sd3263);       // last full neighborhood
		push_query(16'sd3264, 16'sd0);          // one column past the edge
		push_query(16'sd0, 16'sd3264);          // one row past the edge
		push_query(16'sd1, 16'sd3263);
		push_query(-16'sd1, 16'sd0);            // left of the origin
		push_query(16'sd0, -16'sd1);            // below the origin
		push_query(-16'sd32768, -16'sd32768);
		push_query(16'sd32767, 16'sd32767);
		push_query(-16'sd32768, 16'sd32767);
		push_query(16'sd32767, -16'sd32768);
		push_write(0, 0);                       // overwrite a cell already read
		push_query(16'sd0, 16'sd0);
		settle();

		for (int p = 0; p < 9; p++) begin
			gap_pct = (p < 3) ? 14 : (p < 6) ? 69 : 0;
			if (p < 6)
				set_map(plan_ox[p], plan_oy[p], plan_scale[p], plan_cols[p], plan_rows[p]);
			else
				set_map(int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
						: $urandom_range(64, 4096),
					$urandom_range(2, 256), $urandom_range(2, 256));
			fill_random(130);
			settle();
		end

		if (expected_costs.size() != 0)
			report_mismatch("queries never answered", 16'(expected_costs.size()), '0);

		$display("covered %0d items (%0d queries, %0d outside the map)",
			items_taken, queries_taken, outside_seen);
		$display("over %0d map settings with %0d register transfers",
			map_settings + 1, reg_xfers);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
src/cgbs_pkg.sv
src/cgbs_front.sv
src/cgbs_queue.sv
src/cgbs_back.sv
src/cost_grid_bilinear_sampler_core.sv
tb/testbench.sv
